### rtl/encoder_position_velocity_core_defines.svh
// ----------------------------------------------------------------------------
// Encoder position/velocity core assertion macros
// Shared concurrent assertion forms used by the core's RTL.
// ----------------------------------------------------------------------------
`ifndef ENCODER_POSITION_VELOCITY_CORE_DEFINES_SVH
`define ENCODER_POSITION_VELOCITY_CORE_DEFINES_SVH

// same-cycle implication
`define EPV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("epv assertion failed");

// next-cycle implication
`define EPV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("epv assertion failed");

`endif

### rtl/epv_pkg.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity package
// Widths, codes, control structs and clamp helpers shared by the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epv_pkg;

   localparam int COUNT_BITS    = 32;
   localparam int TIME_BITS     = 32;
   localparam int RATE_BITS     = 16;
   localparam int PROD_BITS     = COUNT_BITS + RATE_BITS;
   localparam int DIV_CNT_BITS  = $clog2(PROD_BITS + 1);
   localparam int WIDE_BITS     = (COUNT_BITS > 32 ? COUNT_BITS : 32) + 1;
   localparam int Q_BITS        = (PROD_BITS > 34 ? PROD_BITS : 34);

   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = RATE_BITS;

   typedef enum logic [1:0] {
      CMD_EDGE   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_WRITE  = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   localparam logic [1:0] STAT_NORMAL    = 2'd0;
   localparam logic [1:0] STAT_SATURATED = 2'd1;
   localparam logic [1:0] STAT_ZERO_TIME = 2'd2;
   localparam logic [1:0] STAT_UNUSED    = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATE   = CSR_IDX_BITS'(1);

   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(1000);

   localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;

   localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

   localparam logic signed [WIDE_BITS-1:0] W_I32_MAX = WIDE_BITS'(64'sd2147483647);
   localparam logic signed [WIDE_BITS-1:0] W_I32_MIN = WIDE_BITS'(-64'sd2147483648);
   localparam logic signed [WIDE_BITS-1:0] W_CNT_MAX = WIDE_BITS'(COUNT_MAX);
   localparam logic signed [WIDE_BITS-1:0] W_CNT_MIN = WIDE_BITS'(COUNT_MIN);

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic signed [31:0] clamp_position(
      input logic signed [COUNT_BITS-1:0] c);
      logic signed [WIDE_BITS-1:0] w;
      logic signed [31:0]          r;
      w = WIDE_BITS'(c);
      if (w > W_I32_MAX) begin
         r = VEL_MAX;
      end else if (w < W_I32_MIN) begin
         r = VEL_MIN;
      end else begin
         r = w[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [COUNT_BITS-1:0] clamp_write(
      input logic signed [31:0] v);
      logic signed [WIDE_BITS-1:0]  w;
      logic signed [COUNT_BITS-1:0] r;
      w = WIDE_BITS'(v);
      if (w > W_CNT_MAX) begin
         r = COUNT_MAX;
      end else if (w < W_CNT_MIN) begin
         r = COUNT_MIN;
      end else begin
         r = w[COUNT_BITS-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/epv_channels.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity channels
// Valid/ready interfaces for the request and response items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface epv_req_if import epv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic               dir_level;
   logic [31:0]        time_ms;
   logic signed [31:0] write_value;

   modport source (output valid, command, dir_level, time_ms, write_value,
                   input ready);
   modport sink   (input valid, command, dir_level, time_ms, write_value,
                   output ready);
endinterface

interface epv_rsp_if import epv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] position;
   logic signed [31:0] velocity;
   logic [1:0]         velocity_status;

   modport source (output valid, position, velocity, velocity_status,
                   input ready);
   modport sink   (input valid, position, velocity, velocity_status,
                   output ready);
endinterface

### rtl/epv_divider.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity divider
// Restoring divider, one quotient bit per cycle, shared subtract/compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epv_divider import epv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  div_ctrl_type         ctrl,
   input  logic [PROD_BITS-1:0] dividend,
   input  logic [TIME_BITS-1:0] divisor,
   output div_stat_type         stat,
   output logic [PROD_BITS-1:0] quotient
);

   logic [PROD_BITS-1:0]    dq_ff, dq_in;
   logic [TIME_BITS-1:0]    rem_ff, rem_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [TIME_BITS:0]   shifted;
   logic [TIME_BITS+1:0] trial;
   logic                 qbit;

   always_comb begin
      shifted = {rem_ff, dq_ff[PROD_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, divisor};
      qbit    = ~trial[TIME_BITS+1];

      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.start) begin
         dq_in   = dividend;
         rem_in  = '0;
         cnt_in  = DIV_CNT_BITS'(PROD_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[PROD_BITS-2:0], qbit};
         rem_in = qbit ? trial[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

endmodule

### rtl/encoder_position_velocity_core.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity core
// Step/direction position counter with a sampled velocity estimate.
// ----------------------------------------------------------------------------
// Edge, write and clear items update the signed position count and return one
// response item; the core takes the next request once that response has been
// taken, so a response stall holds off the next item. For a velocity sample
// the position delta is scaled by the rate register in a multiply state and
// then divided by the elapsed milliseconds in a restoring divider that
// resolves one quotient bit per cycle; a sample with no motion or zero
// elapsed time skips the multiply and the divider. Velocity is truncated
// toward zero and saturates to the signed 32-bit range with a status code.
// Request ready is low while an item is in flight. Configuration writes take
// effect at once and are meant to be issued only while the core is idle.
`timescale 1ns / 1ps
`include "encoder_position_velocity_core_defines.svh"

module encoder_position_velocity_core import epv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   epv_req_if.sink                  req_chan,
   epv_rsp_if.source                rsp_chan,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_START,
      ST_DIV,
      ST_FIN,
      ST_RESP,
      ST_WAIT
   } state_type;

   state_type state_ff, state_in;

   logic                         invert_ff, invert_in;
   logic [RATE_BITS-1:0]         rate_ff, rate_in;
   logic signed [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [COUNT_BITS-1:0] samp_count_ff, samp_count_in;
   logic [TIME_BITS-1:0]         samp_time_ff, samp_time_in;
   logic signed [31:0]           speed_ff, speed_in;
   logic [1:0]                   flag_ff, flag_in;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [TIME_BITS-1:0]         dt_ff, dt_in;
   logic [COUNT_BITS-1:0]        mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic [PROD_BITS-1:0]         prod_ff, prod_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]           rsp_pos_ff, rsp_pos_in;
   logic signed [31:0]           rsp_vel_ff, rsp_vel_in;
   logic [1:0]                   rsp_stat_ff, rsp_stat_in;

   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;
   logic [PROD_BITS-1:0] quotient;

   logic                         req_fire;
   cmd_type                      cmd;
   logic signed [COUNT_BITS:0]   diff;
   logic [COUNT_BITS-1:0]        mag_now;
   logic [TIME_BITS-1:0]         dt_now;
   logic [Q_BITS-1:0]            q_ext;

   epv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (prod_ff),
      .divisor  (dt_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.position        = rsp_pos_ff;
   assign rsp_chan.velocity        = rsp_vel_ff;
   assign rsp_chan.velocity_status = rsp_stat_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign cmd      = cmd_type'(req_chan.command);

   always_comb begin
      diff    = {count_ff[COUNT_BITS-1], count_ff}
              - {samp_count_ff[COUNT_BITS-1], samp_count_ff};
      mag_now = diff[COUNT_BITS] ? COUNT_BITS'(-diff) : diff[COUNT_BITS-1:0];
      dt_now  = now_ff - samp_time_ff;
      q_ext   = Q_BITS'(quotient);

      state_in      = state_ff;
      invert_in     = invert_ff;
      rate_in       = rate_ff;
      count_in      = count_ff;
      samp_count_in = samp_count_ff;
      samp_time_in  = samp_time_ff;
      speed_in      = speed_ff;
      flag_in       = flag_ff;
      now_in        = now_ff;
      dt_in         = dt_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_stat_in   = rsp_stat_ff;
      div_ctrl      = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_INVERT: begin
               invert_in = csr_wdata[0];
            end
            CSR_RATE: begin
               rate_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RESP;
               case (cmd)
                  CMD_EDGE: begin
                     if (req_chan.dir_level ^ invert_ff) begin
                        if (count_ff < COUNT_MAX) begin
                           count_in = count_ff + COUNT_BITS'(1);
                        end
                     end else begin
                        if (count_ff > COUNT_MIN) begin
                           count_in = count_ff - COUNT_BITS'(1);
                        end
                     end
                  end
                  CMD_SAMPLE: begin
                     now_in   = TIME_BITS'(req_chan.time_ms);
                     state_in = ST_PREP;
                  end
                  CMD_WRITE: begin
                     count_in = clamp_write(req_chan.write_value);
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PREP: begin
            samp_count_in = count_ff;
            samp_time_in  = now_ff;
            mag_in        = mag_now;
            neg_in        = diff[COUNT_BITS];
            dt_in         = dt_now;
            if (mag_now == '0) begin
               speed_in = '0;
               flag_in  = STAT_NORMAL;
               state_in = ST_RESP;
            end else if (dt_now == '0) begin
               speed_in = diff[COUNT_BITS] ? VEL_MIN : VEL_MAX;
               flag_in  = STAT_ZERO_TIME;
               state_in = ST_RESP;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(mag_ff) * PROD_BITS'(rate_ff);
            state_in = ST_START;
         end
         ST_START: begin
            div_ctrl.start = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (neg_ff) begin
               if (q_ext > Q_BITS'(64'h8000_0000)) begin
                  speed_in = VEL_MIN;
                  flag_in  = STAT_SATURATED;
               end else begin
                  speed_in = 32'd0 - q_ext[31:0];
                  flag_in  = STAT_NORMAL;
               end
            end else begin
               if (q_ext > Q_BITS'(64'h7FFF_FFFF)) begin
                  speed_in = VEL_MAX;
                  flag_in  = STAT_SATURATED;
               end else begin
                  speed_in = q_ext[31:0];
                  flag_in  = STAT_NORMAL;
               end
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = clamp_position(count_ff);
            rsp_vel_in   = speed_ff;
            rsp_stat_in  = flag_ff;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      dt_ff       <= dt_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_vel_ff  <= rsp_vel_in;
      rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         invert_ff     <= 1'b0;
         rate_ff       <= RATE_RESET;
         count_ff      <= '0;
         samp_count_ff <= '0;
         samp_time_ff  <= '0;
         speed_ff      <= '0;
         flag_ff       <= STAT_NORMAL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         invert_ff     <= invert_in;
         rate_ff       <= rate_in;
         count_ff      <= count_in;
         samp_count_ff <= samp_count_in;
         samp_time_ff  <= samp_time_in;
         speed_ff      <= speed_in;
         flag_ff       <= flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `EPV_ASSERT_IMPL(a_ready_no_rsp, clock, reset, req_chan.ready, !rsp_chan.valid)
   `EPV_ASSERT_NEXT(a_short_item, clock, reset, req_fire && cmd != CMD_SAMPLE, state_ff == ST_RESP)
   `EPV_ASSERT_IMPL(a_div_start_idle, clock, reset, div_ctrl.start, !div_stat.busy)
   `EPV_ASSERT_IMPL(a_status_legal, clock, reset, rsp_chan.valid, rsp_chan.velocity_status != STAT_UNUSED)

endmodule

### bench/tb_encoder_position_velocity_core.sv
// ----------------------------------------------------------------------------
// Encoder position/velocity core testbench
// Drives edge, sample, write and clear items through the request channel and
// checks every response item against a predictor of the count and velocity or
// against directed rows that cover count and velocity limits, timer wrap and
// zero rate; then random phases run under several register settings. Both
// channels idle at random, and one long response hold-off backs up the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_encoder_position_velocity_core;
   import epv_pkg::*;

   // longest quiet spell: response hold-off plus a full sample and idle gaps
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 265;

   typedef struct {
      cmd_type            command;
      bit                 dir_level;
      bit [31:0]          time_ms;
      bit signed [31:0]   write_value;
   } enc_request_type;

   typedef struct {
      bit signed [31:0]   position;
      bit signed [31:0]   velocity;
      bit [1:0]           status;
   } reading_type;

   typedef struct {
      bit                       is_csr;
      bit [CSR_IDX_BITS-1:0]    csr_idx;
      bit [CSR_DATA_BITS-1:0]   csr_val;
      enc_request_type          rq;
      bit                       typed;
      reading_type              want;
   } plan_row_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   epv_req_if req();
   epv_rsp_if rsp();

   encoder_position_velocity_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req),
      .rsp_chan  (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predicted state
   bit signed [31:0]       enc_count;
   bit signed [31:0]       mark_count;
   bit [31:0]              mark_time;
   bit signed [31:0]       speed_now;
   bit [1:0]               speed_stat;
   bit                     invert_dir;
   bit [CSR_DATA_BITS-1:0] rate_mult;

   reading_type  pending_readings[$];
   plan_row_type directed_plan[$];
   int           errors = 0;
   bit           steady_flow;
   bit           rsp_hold_pending;
   bit [31:0]    clock_ms;
   bit [31:0]    last_stamp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic reading_type next_reading(enc_request_type r);
      reading_type       o;
      bit [31:0]         dt;
      longint            delta;
      longint unsigned   mag;
      longint unsigned   quo;
      case (r.command)
         CMD_EDGE: begin
            if (r.dir_level ^ invert_dir) begin
               if (enc_count != COUNT_MAX) enc_count = enc_count + 1;
            end else begin
               if (enc_count != COUNT_MIN) enc_count = enc_count - 1;
            end
         end
         CMD_SAMPLE: begin
            dt = r.time_ms - mark_time;
            delta = longint'(enc_count) - longint'(mark_count);
            mag = (delta < 0) ? -delta : delta;
            if (mag == 0) begin
               speed_now = 0;
               speed_stat = STAT_NORMAL;
            end else if (dt == 0) begin
               speed_now = (delta < 0) ? VEL_MIN : VEL_MAX;
               speed_stat = STAT_ZERO_TIME;
            end else begin
               quo = (mag * rate_mult) / dt;
               if (delta < 0) begin
                  if (quo > 64'h8000_0000) begin
                     speed_now = VEL_MIN;
                     speed_stat = STAT_SATURATED;
                  end else begin
                     speed_now = 32'(-longint'(quo));
                     speed_stat = STAT_NORMAL;
                  end
               end else begin
                  if (quo > 64'h7FFF_FFFF) begin
                     speed_now = VEL_MAX;
                     speed_stat = STAT_SATURATED;
                  end else begin
                     speed_now = 32'(quo);
                     speed_stat = STAT_NORMAL;
                  end
               end
            end
            mark_count = enc_count;
            mark_time = r.time_ms;
         end
         CMD_WRITE: begin
            enc_count = r.write_value;
         end
         default: begin
            enc_count = 0;
         end
      endcase
      o.position = enc_count;
      o.velocity = speed_now;
      o.status = speed_stat;
      return o;
   endfunction

   function automatic void plan_check(cmd_type c, bit d, bit [31:0] t, bit signed [31:0] w,
                                      bit signed [31:0] pos, bit signed [31:0] vel,
                                      bit [1:0] st);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.rq.command = c;
      row.rq.dir_level = d;
      row.rq.time_ms = t;
      row.rq.write_value = w;
      row.typed = 1'b1;
      row.want.position = pos;
      row.want.velocity = vel;
      row.want.status = st;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_item(cmd_type c, bit d, bit [31:0] t, bit signed [31:0] w);
      plan_row_type row;
      row.is_csr = 1'b0;
      row.rq.command = c;
      row.rq.dir_level = d;
      row.rq.time_ms = t;
      row.rq.write_value = w;
      row.typed = 1'b0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_csr(bit [CSR_IDX_BITS-1:0] idx, bit [CSR_DATA_BITS-1:0] val);
      plan_row_type row;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_val = val;
      row.typed = 1'b0;
      directed_plan.push_back(row);
   endfunction

   function automatic enc_request_type random_request();
      enc_request_type r;
      int              pick;
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(3);
      if (pick < 50) r.command = CMD_EDGE;
      else if (pick < 75) r.command = CMD_SAMPLE;
      else if (pick < 90) r.command = CMD_WRITE;
      else r.command = CMD_CLEAR;
      r.dir_level = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 8) r.time_ms = $urandom;
      else if (pick < 16) r.time_ms = last_stamp;
      else r.time_ms = clock_ms;
      if (r.command == CMD_SAMPLE) last_stamp = r.time_ms;
      pick = $urandom_range(99);
      if (pick < 50) r.write_value = $urandom_range(2000) - 1000;
      else if (pick < 80) r.write_value = $urandom;
      else if (pick < 90) r.write_value = COUNT_MAX - $urandom_range(3);
      else r.write_value = COUNT_MIN + $urandom_range(3);
      return r;
   endfunction

   task automatic offer_item(input enc_request_type rq, input bit typed,
                             input reading_type want);
      reading_type got;
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 25) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid = 1'b1;
      req.command = rq.command;
      req.dir_level = rq.dir_level;
      req.time_ms = rq.time_ms;
      req.write_value = rq.write_value;
      do @(posedge clock); while (!req.ready);
      got = next_reading(rq);
      pending_readings.push_back(typed ? want : got);
   endtask

   task automatic configure(input bit [CSR_IDX_BITS-1:0] idx,
                            input bit [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_INVERT) invert_dir = val[0];
      else if (idx == CSR_RATE) rate_mult = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // response side: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_pending && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            rsp.ready = 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp.ready = steady_flow || ($urandom_range(99) >= 25);
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected item: position %0d velocity %0d status %0d",
                     $time, rsp.position, rsp.velocity, rsp.velocity_status);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp.position !== want.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp.position);
               errors++;
            end
            if (rsp.velocity !== want.velocity) begin
               $display("%0t: velocity expected %0d actual %0d",
                        $time, want.velocity, rsp.velocity);
               errors++;
            end
            if (rsp.velocity_status !== want.status) begin
               $display("%0t: velocity_status expected %0d actual %0d",
                        $time, want.status, rsp.velocity_status);
               errors++;
            end
         end
      end
   end

   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall = 0;
         else stall = stall + 1;
      end
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_encoder_position_velocity_core NOT OK");
      $finish;
   end

   initial begin
      reading_type blank;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.command = CMD_EDGE;
      req.dir_level = 1'b0;
      req.time_ms = '0;
      req.write_value = '0;
      enc_count = 0;
      mark_count = 0;
      mark_time = 0;
      speed_now = 0;
      speed_stat = STAT_NORMAL;
      invert_dir = 1'b0;
      rate_mult = RATE_RESET;
      steady_flow = 1'b0;
      rsp_hold_pending = 1'b0;
      clock_ms = 0;
      last_stamp = 0;
      blank = '{default: 0};

      // limits, no motion, zero time, saturation
      plan_check(CMD_CLEAR,  1'b0, 32'd0, 32'sd0, 32'sd0, 32'sd0, STAT_NORMAL);
      plan_check(CMD_EDGE,   1'b1, 32'd0, 32'sd0, 32'sd1, 32'sd0, STAT_NORMAL);
      plan_check(CMD_EDGE,   1'b0, 32'd0, 32'sd0, 32'sd0, 32'sd0, STAT_NORMAL);
      plan_check(CMD_SAMPLE, 1'b0, 32'd0, 32'sd0, 32'sd0, 32'sd0, STAT_NORMAL);
      plan_check(CMD_WRITE,  1'b0, 32'd0, COUNT_MAX, COUNT_MAX, 32'sd0, STAT_NORMAL);
      plan_check(CMD_EDGE,   1'b1, 32'd0, 32'sd0, COUNT_MAX, 32'sd0, STAT_NORMAL);
      plan_check(CMD_SAMPLE, 1'b0, 32'd0, 32'sd0, COUNT_MAX, VEL_MAX, STAT_ZERO_TIME);
      plan_check(CMD_WRITE,  1'b1, 32'hFFFF_FFFF, COUNT_MIN, COUNT_MIN, VEL_MAX,
                 STAT_ZERO_TIME);
      plan_check(CMD_EDGE,   1'b0, 32'd0, 32'sd0, COUNT_MIN, VEL_MAX, STAT_ZERO_TIME);
      plan_check(CMD_SAMPLE, 1'b0, 32'd1, 32'sd0, COUNT_MIN, VEL_MIN, STAT_SATURATED);
      plan_check(CMD_SAMPLE, 1'b1, 32'd1, -32'sd1, COUNT_MIN, 32'sd0, STAT_NORMAL);
      // timer wrap and truncation toward zero
      plan_item(CMD_WRITE,  1'b0, 32'd0, -32'sd1);
      plan_item(CMD_SAMPLE, 1'b0, 32'hFFFF_FFF0, 32'sd0);
      plan_item(CMD_WRITE,  1'b0, 32'd0, 32'sd1064);
      plan_item(CMD_SAMPLE, 1'b0, 32'h0000_0010, 32'sd0);
      plan_item(CMD_WRITE,  1'b0, 32'd0, 32'sd1057);
      plan_item(CMD_SAMPLE, 1'b0, 32'h0000_0013, 32'sd0);
      // inverted direction
      plan_csr(CSR_INVERT, CSR_DATA_BITS'(1));
      plan_item(CMD_EDGE,   1'b1, 32'd0, 32'sd0);
      plan_item(CMD_EDGE,   1'b0, 32'd0, 32'sd0);
      // zero rate, with and without elapsed time
      plan_csr(CSR_RATE, CSR_DATA_BITS'(0));
      plan_item(CMD_EDGE,   1'b1, 32'd0, 32'sd0);
      plan_item(CMD_SAMPLE, 1'b0, 32'h0000_0020, 32'sd0);
      plan_item(CMD_EDGE,   1'b0, 32'd0, 32'sd0);
      plan_item(CMD_SAMPLE, 1'b0, 32'h0000_0020, 32'sd0);
      // largest rate
      plan_csr(CSR_RATE, 16'hFFFF);
      plan_item(CMD_WRITE,  1'b0, 32'd0, 32'sd40000);
      plan_item(CMD_SAMPLE, 1'b0, 32'h0000_0021, 32'sd0);
      plan_csr(CSR_INVERT, CSR_DATA_BITS'(0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            configure(directed_plan[i].csr_idx, directed_plan[i].csr_val);
         end else begin
            offer_item(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);
         end
      end

      clock_ms = 32'h0000_0100;
      last_stamp = clock_ms;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               configure(CSR_INVERT, CSR_DATA_BITS'(0));
               configure(CSR_RATE, CSR_DATA_BITS'(1));
            end
            1: begin
               configure(CSR_INVERT, CSR_DATA_BITS'(1));
               configure(CSR_RATE, 16'hFFFF);
            end
            2: begin
               configure(CSR_INVERT, CSR_DATA_BITS'($urandom_range(1)));
               configure(CSR_RATE, CSR_DATA_BITS'($urandom_range(65535, 1)));
               steady_flow = 1'b1;
            end
            3: begin
               steady_flow = 1'b0;
               configure(CSR_INVERT, CSR_DATA_BITS'(0));
               configure(CSR_RATE, CSR_DATA_BITS'(0));
            end
            4: begin
               configure(CSR_INVERT, CSR_DATA_BITS'(1));
               configure(CSR_RATE, CSR_DATA_BITS'($urandom_range(65535, 1)));
               rsp_hold_pending = 1'b1;
            end
            default: begin
               configure(CSR_INVERT, CSR_DATA_BITS'($urandom_range(1)));
               configure(CSR_RATE, RATE_RESET);
               clock_ms = 32'hFFFF_FE00;
            end
         endcase
         repeat (PHASE_ITEMS) offer_item(random_request(), 1'b0, blank);
      end

      @(negedge clock);
      req.valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0 && pending_readings.size() == 0) begin
         $display("tb_encoder_position_velocity_core OK");
      end else begin
         $display("tb_encoder_position_velocity_core NOT OK");
      end
      $finish;
   end

endmodule
